@@ hw/rtl/qpe_pkg.sv @@
// Shared constants, command and status structs and helpers of the quoted-printable encoder.
package qpe_pkg;

    localparam int PEND_DEPTH = 5;
    localparam int CNT_W      = $clog2(PEND_DEPTH + 1);
    localparam int IDX_W      = $clog2(PEND_DEPTH);
    localparam int LEN_W      = 3;
    localparam int FROM_LEN   = 5;

    localparam logic [7:0] BREAK_RESET = 8'd72;
    localparam logic [7:0] CH_EQ       = 8'h3D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_F        = 8'h46;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_O        = 8'h6F;
    localparam logic [7:0] CH_M        = 8'h6D;
    localparam logic [7:0] PRINT_LO    = 8'h21;
    localparam logic [7:0] PRINT_HI    = 8'h7E;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_HEXA  = 8'h37;

    // Controller to datapath
    typedef struct packed {
        logic             push_port;
        logic             save_in;
        logic             push_saved;
        logic             end_set;
        logic             end_clr;
        logic             emit;
        logic             commit;
        logic             release_hold;
        logic [LEN_W-1:0] k;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             resolve;
        logic             full;
        logic             can_step;
        logic [LEN_W-1:0] len;
    } t_status;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = ASCII_ZERO + {4'h0, n};
        end else begin
            r = ASCII_HEXA + {4'h0, n};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/quoted_printable_encoder.sv @@
// Top level of the quoted-printable encoder: controller plus datapath.
// A word is taken, the oldest pending byte is evaluated and its characters are emitted
//   into a hold stage; a held character moves on to the output register when another is
//   emitted or the run ends. Words are taken one at a time: o_ready stays low until the
//   previous word's run, with any closing soft break, has been emitted and released.
// Reset: synchronous, active low; column and queue count clear, break column returns to 72.
module quoted_printable_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input words
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [7:0] i_data_byte,
    // output words
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    // break column register
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);
    import qpe_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The controller steps through: take a word, evaluate the oldest pending byte, emit
    // its characters one per cycle while the output can take them, and repeat until the front
    // needs more lookahead or the queue is empty. The final character of a run sits in a hold
    // stage until the run is known to be over, so that its last flag can be set.
    qpe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath holds the lookahead queue, the column count, the break column
    // and the hold and output registers that decouple emission from the sink.
    qpe_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

@@ hw/rtl/qpe_datapath.sv @@
// Datapath: pending byte queue, column tracking, character planning and output staging.
module qpe_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_data_byte,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  qpe_pkg::t_cmd    i_cmd,
    output qpe_pkg::t_status o_status,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run
);
    import qpe_pkg::*;

    logic [7:0]       r_break;
    logic [7:0]       r_column;
    logic [7:0]       r_q [PEND_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic             r_at_end;
    logic [7:0]       r_in_byte;
    logic [7:0]       r_hold;
    logic             r_hold_v;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_v;

    logic [7:0]       c;
    logic             have_front, la1, la4, eol1, col0;
    logic             is_f, is_dot, is_ws, is_lf, wait_more;
    logic             quote_pre, quote_body, quote, sb, tail;
    logic [8:0]       col1, base, n_col9;
    logic [7:0]       n_col;
    logic             p_sb;
    logic [LEN_W-1:0] len, kk;
    logic [7:0]       ch;
    logic             out_free, can_step, load_out;

    // Plan for the oldest pending byte
    always_comb begin
        c          = r_q[0];
        have_front = (r_count != '0);
        la1        = (r_count >= CNT_W'(2));
        la4        = (r_count >= CNT_W'(FROM_LEN));
        eol1       = (r_q[1] == CH_CR) || (r_q[1] == CH_LF);
        col0       = (r_column == 8'd0);
        is_f       = col0 && (c == CH_F);
        is_dot     = col0 && !is_f && (c == CH_DOT);
        is_ws      = (c == CH_SP) || (c == CH_TAB);
        is_lf      = (c == CH_LF);

        if (is_f) begin
            wait_more = !la4 && !r_at_end;
            quote_pre = la4 && (r_q[1] == CH_R) && (r_q[2] == CH_O) &&
                        (r_q[3] == CH_M) && (r_q[4] == CH_SP);
        end else if (is_dot) begin
            wait_more = !la1 && !r_at_end;
            quote_pre = la1 && eol1;
        end else begin
            wait_more = is_ws && !la1 && !r_at_end;
            quote_pre = 1'b0;
        end

        col1 = {1'b0, r_column} + 9'd1;
        sb   = !quote_pre && !is_lf && (col1 >= {1'b0, r_break});
        base = sb ? 9'd0 : col1;
        if (quote_pre || is_lf) begin
            quote_body = 1'b0;
        end else if (is_ws) begin
            quote_body = la1 && eol1;
        end else begin
            quote_body = !((c >= PRINT_LO) && (c <= PRINT_HI) && (c != CH_EQ));
        end
        quote = quote_pre || quote_body;

        priority if (quote_pre) begin
            n_col9 = col1 + 9'd2;
        end else if (is_lf) begin
            n_col9 = 9'd0;
        end else if (quote_body) begin
            n_col9 = base + 9'd2;
        end else if (c == CH_TAB) begin
            n_col9 = {base[8:3], 3'b111};
        end else begin
            n_col9 = base;
        end
        n_col = n_col9[8] ? 8'hFF : n_col9[7:0];

        // End-of-stream soft break once the queue is empty
        tail = !have_front && r_at_end && !col0;
        p_sb = have_front ? sb : 1'b1;

        len = (p_sb ? LEN_W'(2) : LEN_W'(0)) +
              (have_front ? (quote ? LEN_W'(3) : LEN_W'(1)) : LEN_W'(0));
        kk  = i_cmd.k - (p_sb ? LEN_W'(2) : LEN_W'(0));

        if (p_sb && (i_cmd.k == LEN_W'(0))) begin
            ch = CH_EQ;
        end else if (p_sb && (i_cmd.k == LEN_W'(1))) begin
            ch = CH_LF;
        end else if (quote) begin
            if (kk == LEN_W'(0)) begin
                ch = CH_EQ;
            end else if (kk == LEN_W'(1)) begin
                ch = hex_digit(c[7:4]);
            end else begin
                ch = hex_digit(c[3:0]);
            end
        end else begin
            ch = c;
        end
    end

    assign out_free = !r_out_v || i_ready;
    assign can_step = !r_hold_v || out_free;
    assign load_out = (i_cmd.emit || i_cmd.release_hold) && r_hold_v;

    assign o_status.resolve  = have_front ? !wait_more : tail;
    assign o_status.full     = (r_count == CNT_W'(PEND_DEPTH));
    assign o_status.can_step = can_step;
    assign o_status.len      = len;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break  <= BREAK_RESET;
            r_column <= 8'd0;
            r_count  <= '0;
            r_at_end <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_break <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_column <= have_front ? n_col : 8'd0;
            end
            priority if (i_cmd.commit && have_front) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.push_port || i_cmd.push_saved) begin
                r_count <= r_count + CNT_W'(1);
            end
            priority if (i_cmd.end_set) begin
                r_at_end <= 1'b1;
            end else if (i_cmd.end_clr) begin
                r_at_end <= 1'b0;
            end
            priority if (i_cmd.emit) begin
                r_hold_v <= 1'b1;
            end else if (i_cmd.release_hold) begin
                r_hold_v <= 1'b0;
            end
            priority if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_in) begin
            r_in_byte <= i_data_byte;
        end
        priority if (i_cmd.commit && have_front) begin
            for (int i = 0; i < PEND_DEPTH - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
        end else if (i_cmd.push_port) begin
            r_q[r_count[IDX_W-1:0]] <= i_data_byte;
        end else if (i_cmd.push_saved) begin
            r_q[r_count[IDX_W-1:0]] <= r_in_byte;
        end
        if (i_cmd.emit) begin
            r_hold <= ch;
        end
        if (load_out) begin
            r_out_byte <= r_hold;
            r_out_last <= i_cmd.release_hold;
        end
    end

    assign o_valid       = r_out_v;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PEND_DEPTH))
        else $error("pending count beyond queue depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_port || i_cmd.push_saved) |-> (r_count < CNT_W'(PEND_DEPTH)))
        else $error("push into full queue");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.release_hold) |-> can_step)
        else $error("word staged while output stalled");

    a_tail_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !have_front) |-> r_at_end)
        else $error("soft break tail outside flush");

    a_release_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.release_hold && !i_cmd.emit) |=> !r_hold_v)
        else $error("held word survived release");

endmodule

@@ hw/rtl/qpe_ctrl.sv @@
// Controller: sequences acceptance, front evaluation, character emission and run completion.
module qpe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_action,
    output logic             o_ready,
    input  qpe_pkg::t_status i_status,
    output qpe_pkg::t_cmd    o_cmd
);
    import qpe_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_EMIT   = 5'b00100,
        S_PUSH   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_k, n_k;
    logic             r_pre, n_pre;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_pre   = r_pre;
        o_cmd   = '0;
        o_cmd.k = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EVAL;
                    if (i_action) begin
                        o_cmd.end_set = 1'b1;
                    end else if (i_status.full) begin
                        // drain the oldest word as at end of stream, then push
                        o_cmd.save_in = 1'b1;
                        o_cmd.end_set = 1'b1;
                        n_pre         = 1'b1;
                    end else begin
                        o_cmd.push_port = 1'b1;
                        o_cmd.end_clr   = 1'b1;
                    end
                end
            end
            S_EVAL: begin
                n_k     = '0;
                n_state = i_status.resolve ? S_EMIT : S_FINISH;
            end
            S_EMIT: begin
                if (i_status.can_step) begin
                    o_cmd.emit = 1'b1;
                    if (r_k == i_status.len - LEN_W'(1)) begin
                        o_cmd.commit = 1'b1;
                        n_state      = r_pre ? S_PUSH : S_EVAL;
                    end else begin
                        n_k = r_k + LEN_W'(1);
                    end
                end
            end
            S_PUSH: begin
                o_cmd.push_saved = 1'b1;
                o_cmd.end_clr    = 1'b1;
                n_pre            = 1'b0;
                n_state          = S_EVAL;
            end
            S_FINISH: begin
                if (i_status.can_step) begin
                    o_cmd.release_hold = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_pre   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pre   <= n_pre;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule
